// ===== hdl/tbr_pkg.sv =====
// tile blit row generator package: field widths, divider sizing and the
// structs passed between the pipeline stages; no dependencies
`default_nettype none

package tbr_pkg;

    localparam int REG_W      = 13;  // configuration registers
    localparam int CELL_W     = 8;   // map column and row
    localparam int TILE_W     = 16;  // tile number, also the divider dividend
    localparam int OFS_W      = 24;  // pixel offsets, wrap at this width
    localparam int RUN_W      = 7;   // run length and row count
    localparam int POS_W      = 15;  // screen position, holds 256 tiles of 64 pixels
    localparam int CFG_IDX_W  = 2;

    localparam int TILE_PIXELS_DEFAULT = 32;

    // quotient bits produced per divider stage
    localparam int DIV_STEP   = 2;
    localparam int DIV_STAGES = TILE_W / DIV_STEP;

    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [RUN_W-1:0] run;
        logic [RUN_W-1:0] rows;
    } geom_t;

    // one divider stage: partial remainder, dividend bits shifting out while
    // quotient bits shift in, plus the tile geometry riding along
    typedef struct packed {
        logic             valid;
        logic [REG_W-1:0] rem;
        logic [TILE_W-1:0] work;
        geom_t            geom;
    } div_t;

    typedef struct packed {
        logic             valid;
        logic [OFS_W-1:0] dest;
        logic [OFS_W-1:0] src;
        logic [RUN_W-1:0] run;
        logic [RUN_W-1:0] rows;
    } blit_t;

endpackage

`default_nettype wire

// ===== hdl/tbr_div_stage.sv =====
// one stage of the pipelined restoring divider, DIV_STEP quotient bits per stage
// depends on tbr_pkg
`default_nettype none

module tbr_div_stage (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    advance,
    input  wire logic [tbr_pkg::REG_W-1:0] divisor,
    input  wire tbr_pkg::div_t           stage_in,
    output tbr_pkg::div_t                stage_out
);

    tbr_pkg::div_t                stage_next;
    tbr_pkg::div_t                data_reg;
    logic                         valid_reg;
    logic [tbr_pkg::REG_W:0]      trial;
    logic [tbr_pkg::REG_W-1:0]    rem;
    logic [tbr_pkg::TILE_W-1:0]   work;

    always_comb
    begin
        rem   = stage_in.rem;
        work  = stage_in.work;
        trial = '0;
        for (int i = 0; i < tbr_pkg::DIV_STEP; i++)
        begin
            trial = {rem, work[tbr_pkg::TILE_W-1]};
            work  = {work[tbr_pkg::TILE_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor})
            begin
                trial   = trial - {1'b0, divisor};
                work[0] = 1'b1;
            end
            rem = trial[tbr_pkg::REG_W-1:0];
        end
        stage_next       = stage_in;
        stage_next.rem   = rem;
        stage_next.work  = work;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= stage_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= stage_next;
        end
    end

    always_comb
    begin
        stage_out       = data_reg;
        stage_out.valid = valid_reg;
    end

endmodule

`default_nettype wire

// ===== hdl/tbr_offset.sv =====
// two stage offset unit: palette position and destination base, then source base
// depends on tbr_pkg
`default_nettype none

module tbr_offset #(
    parameter int TILE_PIXELS = tbr_pkg::TILE_PIXELS_DEFAULT
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      advance,
    input  wire logic [tbr_pkg::REG_W-1:0] screen_width,
    input  wire logic [tbr_pkg::REG_W-1:0] palette_width,
    input  wire tbr_pkg::div_t             div_in,
    output tbr_pkg::blit_t                 blit_out
);

    localparam int OFS_W  = tbr_pkg::OFS_W;
    localparam int DPROD_W = tbr_pkg::POS_W + tbr_pkg::REG_W;
    localparam int SPROD_W = OFS_W + tbr_pkg::REG_W;

    logic                          m1_valid_reg;
    logic [OFS_W-1:0]              m1_sx_reg;
    logic [OFS_W-1:0]              m1_sy_reg;
    logic [OFS_W-1:0]              m1_dest_reg;
    logic [tbr_pkg::RUN_W-1:0]     m1_run_reg;
    logic [tbr_pkg::RUN_W-1:0]     m1_rows_reg;

    logic [OFS_W-1:0]              sx_next;
    logic [OFS_W-1:0]              sy_next;
    logic [DPROD_W-1:0]            dest_prod;
    logic [OFS_W-1:0]              dest_next;
    logic [SPROD_W-1:0]            src_prod;
    logic [OFS_W-1:0]              src_next;

    logic                          out_valid_reg;
    tbr_pkg::blit_t                out_reg;

    // quotient is the palette row, remainder the palette column
    always_comb
    begin
        sx_next   = OFS_W'(div_in.rem) * OFS_W'(TILE_PIXELS);
        sy_next   = OFS_W'(div_in.work) * OFS_W'(TILE_PIXELS);
        dest_prod = DPROD_W'(div_in.geom.y) * DPROD_W'(screen_width);
        dest_next = OFS_W'(div_in.geom.x) + dest_prod[OFS_W-1:0];
        src_prod  = SPROD_W'(m1_sy_reg) * SPROD_W'(palette_width);
        src_next  = m1_sx_reg + src_prod[OFS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            m1_valid_reg  <= div_in.valid;
            out_valid_reg <= m1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m1_sx_reg     <= sx_next;
            m1_sy_reg     <= sy_next;
            m1_dest_reg   <= dest_next;
            m1_run_reg    <= div_in.geom.run;
            m1_rows_reg   <= div_in.geom.rows;
            out_reg.valid <= m1_valid_reg;
            out_reg.dest  <= m1_dest_reg;
            out_reg.src   <= src_next;
            out_reg.run   <= m1_run_reg;
            out_reg.rows  <= m1_rows_reg;
        end
    end

    always_comb
    begin
        blit_out       = out_reg;
        blit_out.valid = out_valid_reg;
    end

endmodule

`default_nettype wire

// ===== hdl/tbr_row_emit.sv =====
// row emitter: steps one tile's base offsets down its visible rows, one per cycle
// depends on tbr_pkg
`default_nettype none

module tbr_row_emit (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [tbr_pkg::REG_W-1:0] screen_width,
    input  wire logic [tbr_pkg::REG_W-1:0] palette_width,
    input  wire tbr_pkg::blit_t            blit_in,
    output logic                           take,
    output logic                           strobe,
    output logic [tbr_pkg::OFS_W-1:0]      dest_offset,
    output logic [tbr_pkg::OFS_W-1:0]      source_offset,
    output logic [tbr_pkg::RUN_W-1:0]      run_length,
    output logic                           last_row
);

    localparam int OFS_W = tbr_pkg::OFS_W;

    logic                          active_reg;
    logic [OFS_W-1:0]              dest_reg;
    logic [OFS_W-1:0]              src_reg;
    logic [tbr_pkg::RUN_W-1:0]     run_reg;
    logic [tbr_pkg::RUN_W-1:0]     rows_left_reg;
    logic                          final_row;
    logic                          load;

    assign final_row = (rows_left_reg == tbr_pkg::RUN_W'(1));
    // free now, or handing out the last row of the current tile this cycle
    assign take      = !active_reg || final_row;
    assign load      = blit_in.valid && take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else if (load)
        begin
            active_reg <= 1'b1;
        end
        else if (final_row)
        begin
            active_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            dest_reg      <= blit_in.dest;
            src_reg       <= blit_in.src;
            run_reg       <= blit_in.run;
            rows_left_reg <= blit_in.rows;
        end
        else if (active_reg)
        begin
            dest_reg      <= dest_reg + OFS_W'(screen_width);
            src_reg       <= src_reg + OFS_W'(palette_width);
            rows_left_reg <= rows_left_reg - tbr_pkg::RUN_W'(1);
        end
    end

    assign strobe        = active_reg;
    assign dest_offset   = dest_reg;
    assign source_offset = src_reg;
    assign run_length    = run_reg;
    assign last_row      = final_row;

endmodule

`default_nettype wire

// ===== hdl/tile_blit_row_generator.sv =====
// tile blit row generator top level: config registers, item entry and clip,
// divider chain, offset unit and row emitter; depends on tbr_pkg and submodules
//
// usage:
//   an item (one map cell) is accepted on a rising edge with start high and
//   busy low. each visible tile row comes out as one result on dest_offset,
//   source_offset, run_length and last_row, valid for exactly one cycle while
//   strobe is high; last_row marks the final row of the tile. empty or fully
//   clipped cells give nothing.
//   configuration writes go over cfg_valid/cfg_ready (always ready) with
//   cfg_index 0 screen width, 1 screen height, 2 palette width; index 3 is
//   ignored. write only while no item is in flight.
//   path: entry register, DIV_STAGES divider stages of DIV_STEP quotient
//   bits each, two offset stages, then the emitter, whose register drives
//   the first row's strobe.
//   throughput: the emitter gives one row per cycle, so a visible tile keeps
//   it until its last visible row (up to TILE_PIXELS rows); busy rises
//   while the emitter is still on a tile and another waits behind it.
//   cells that give no rows pass at one per cycle while busy is low.
//   reset clears all valid bits and loads 640, 480 and 256 into the registers.
//   the receiver cannot stall, so results never wait.
`default_nettype none

module tile_blit_row_generator #(
    parameter int TILE_PIXELS = tbr_pkg::TILE_PIXELS_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [tbr_pkg::CELL_W-1:0]    cell_column,
    input  wire logic [tbr_pkg::CELL_W-1:0]    cell_row,
    input  wire logic [tbr_pkg::TILE_W-1:0]    tile_number,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [tbr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tbr_pkg::REG_W-1:0]     cfg_data,
    output logic                               strobe,
    output logic [tbr_pkg::OFS_W-1:0]          dest_offset,
    output logic [tbr_pkg::OFS_W-1:0]          source_offset,
    output logic [tbr_pkg::RUN_W-1:0]          run_length,
    output logic                               last_row
);

    localparam int REG_W  = tbr_pkg::REG_W;
    localparam int POS_W  = tbr_pkg::POS_W;
    localparam int RUN_W  = tbr_pkg::RUN_W;

    localparam logic [REG_W-1:0] SCREEN_WIDTH_RESET  = REG_W'(640);
    localparam logic [REG_W-1:0] SCREEN_HEIGHT_RESET = REG_W'(480);
    localparam logic [REG_W-1:0] PALETTE_WIDTH_RESET = REG_W'(256);

    // tiles per palette row by reciprocal multiply, exact for 13-bit widths
    localparam int     RECIP_SHIFT = 20;
    localparam int     PROD_W      = REG_W + RECIP_SHIFT + 1;
    localparam longint RECIP       = ((64'd1 << RECIP_SHIFT) + TILE_PIXELS - 1) / TILE_PIXELS;
    localparam int     PER_ROW_RAW = 256 / TILE_PIXELS;
    localparam logic [REG_W-1:0] PER_ROW_RESET =
        (PER_ROW_RAW == 0) ? REG_W'(1) : REG_W'(PER_ROW_RAW);

    typedef enum logic [tbr_pkg::CFG_IDX_W-1:0] {
        REG_SCREEN_WIDTH,
        REG_SCREEN_HEIGHT,
        REG_PALETTE_WIDTH
    } cfg_reg_t;

    logic [REG_W-1:0]   screen_width_reg;
    logic [REG_W-1:0]   screen_height_reg;
    logic [REG_W-1:0]   palette_width_reg;
    logic [REG_W-1:0]   per_row_reg;
    logic [REG_W-1:0]   per_row_next;
    logic [PROD_W-1:0]  per_row_prod;

    logic               advance;
    logic               accept;
    logic               take;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [POS_W-1:0]   end_x;
    logic [POS_W-1:0]   end_y;
    logic               visible;
    tbr_pkg::div_t      entry_next;
    tbr_pkg::div_t      entry_reg;
    logic               entry_valid_reg;
    tbr_pkg::div_t      div_chain [0:tbr_pkg::DIV_STAGES];
    tbr_pkg::blit_t     blit;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= SCREEN_WIDTH_RESET;
            screen_height_reg <= SCREEN_HEIGHT_RESET;
            palette_width_reg <= PALETTE_WIDTH_RESET;
            per_row_reg       <= PER_ROW_RESET;
        end
        else
        begin
            per_row_reg <= per_row_next;
            if (cfg_valid)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data;
                    REG_SCREEN_HEIGHT: screen_height_reg <= cfg_data;
                    REG_PALETTE_WIDTH: palette_width_reg <= cfg_data;
                    default:           ;
                endcase
            end
        end
    end

    always_comb
    begin
        per_row_prod = PROD_W'(palette_width_reg) * PROD_W'(RECIP);
        per_row_next = per_row_prod[RECIP_SHIFT +: REG_W];
        if (per_row_next == '0)
        begin
            per_row_next = REG_W'(1);
        end
    end

    // whole pipeline moves together; it holds only when the emitter cannot take
    assign advance = !(blit.valid && !take);
    assign busy    = !advance;
    assign accept  = start && advance;

    always_comb
    begin
        pos_x   = POS_W'(cell_column) * POS_W'(TILE_PIXELS);
        pos_y   = POS_W'(cell_row) * POS_W'(TILE_PIXELS);
        end_x   = pos_x + POS_W'(TILE_PIXELS);
        end_y   = pos_y + POS_W'(TILE_PIXELS);
        if (end_x > POS_W'(screen_width_reg))
        begin
            end_x = POS_W'(screen_width_reg);
        end
        if (end_y > POS_W'(screen_height_reg))
        begin
            end_y = POS_W'(screen_height_reg);
        end
        visible = (tile_number != '0)
               && (pos_x < POS_W'(screen_width_reg))
               && (pos_y < POS_W'(screen_height_reg));

        entry_next           = '0;
        entry_next.valid     = accept && visible;
        entry_next.rem       = '0;
        entry_next.work      = tile_number - tbr_pkg::TILE_W'(1);
        entry_next.geom.x    = pos_x;
        entry_next.geom.y    = pos_y;
        entry_next.geom.run  = RUN_W'(end_x - pos_x);
        entry_next.geom.rows = RUN_W'(end_y - pos_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            entry_valid_reg <= entry_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            entry_reg <= entry_next;
        end
    end

    always_comb
    begin
        div_chain[0]       = entry_reg;
        div_chain[0].valid = entry_valid_reg;
    end

    for (genvar g = 0; g < tbr_pkg::DIV_STAGES; g++)
    begin : g_div
        tbr_div_stage u_div_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .divisor   (per_row_reg),
            .stage_in  (div_chain[g]),
            .stage_out (div_chain[g+1])
        );
    end

    tbr_offset #(
        .TILE_PIXELS (TILE_PIXELS)
    ) u_offset (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .screen_width  (screen_width_reg),
        .palette_width (palette_width_reg),
        .div_in        (div_chain[tbr_pkg::DIV_STAGES]),
        .blit_out      (blit)
    );

    tbr_row_emit u_row_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .screen_width  (screen_width_reg),
        .palette_width (palette_width_reg),
        .blit_in       (blit),
        .take          (take),
        .strobe        (strobe),
        .dest_offset   (dest_offset),
        .source_offset (source_offset),
        .run_length    (run_length),
        .last_row      (last_row)
    );

endmodule

`default_nettype wire

// ===== tb/tbr_test_pkg.sv =====
// shared names for the tile blit row generator testbench: tile size and
// configuration register indexes; depends on nothing
package tbr_test_pkg;

    localparam int TILE_PIXELS = 32;

    typedef enum logic [1:0] {
        CFG_SCREEN_WIDTH  = 2'd0,
        CFG_SCREEN_HEIGHT = 2'd1,
        CFG_PALETTE_WIDTH = 2'd2,
        CFG_UNUSED        = 2'd3
    } cfg_reg_t;

endpackage

// ===== tb/tile_blit_row_generator_checker.sv =====
// row descriptor checker for the tile blit row generator: follows config
// writes and accepted cells, predicts each visible tile row and compares it
// with the strobed results; depends on tbr_test_pkg
module tile_blit_row_generator_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [7:0]  cell_column,
    input  logic [7:0]  cell_row,
    input  logic [15:0] tile_number,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        strobe,
    input  logic [23:0] dest_offset,
    input  logic [23:0] source_offset,
    input  logic [6:0]  run_length,
    input  logic        last_row,
    output int          rows_pending,
    output int          fail_count
);

    localparam int TILE_PIXELS = tbr_test_pkg::TILE_PIXELS;

    typedef struct {
        logic [23:0] dest;
        logic [23:0] src;
        logic [6:0]  run;
        logic        last;
    } row_desc_t;

    row_desc_t   expected_rows[$];
    logic [12:0] screen_width;
    logic [12:0] screen_height;
    logic [12:0] palette_width;

    task automatic report_mismatch(input string what, input longint want, input longint got);
        $display("%0t: %s mismatch, expected %0d got %0d", $realtime, what, want, got);
        fail_count++;
    endtask

    task automatic apply_register(input logic [1:0] index, input logic [12:0] value);
        case (tbr_test_pkg::cfg_reg_t'(index))
            tbr_test_pkg::CFG_SCREEN_WIDTH:  screen_width = value;
            tbr_test_pkg::CFG_SCREEN_HEIGHT: screen_height = value;
            tbr_test_pkg::CFG_PALETTE_WIDTH: palette_width = value;
            default: ;
        endcase
    endtask

    task automatic predict_tile_rows(input logic [7:0] col, input logic [7:0] row,
                                     input logic [15:0] tile);
        bit [63:0] x, y, xend, yend, run, rows, per_row, idx, sx, sy;
        row_desc_t d;
        if (tile == 16'd0)
            return;
        x = 64'(col) * TILE_PIXELS;
        y = 64'(row) * TILE_PIXELS;
        if (x >= 64'(screen_width) || y >= 64'(screen_height))
            return;
        xend = x + TILE_PIXELS;
        if (xend > 64'(screen_width))
            xend = 64'(screen_width);
        yend = y + TILE_PIXELS;
        if (yend > 64'(screen_height))
            yend = 64'(screen_height);
        run = xend - x;
        rows = yend - y;
        if (run == 0 || rows == 0)
            return;
        // narrow palettes still hold one tile per row
        per_row = 64'(palette_width) / TILE_PIXELS;
        if (per_row == 0)
            per_row = 1;
        idx = 64'(tile) - 1;
        sx = (idx % per_row) * TILE_PIXELS;
        sy = (idx / per_row) * TILE_PIXELS;
        for (bit [63:0] r = 0; r < rows; r++)
        begin
            d.dest = 24'(x + (y + r) * 64'(screen_width));
            d.src  = 24'(sx + (sy + r) * 64'(palette_width));
            d.run  = 7'(run);
            d.last = (r + 1 == rows);
            expected_rows.push_back(d);
        end
    endtask

    task automatic check_row;
        row_desc_t want;
        if (expected_rows.size() == 0)
        begin
            report_mismatch("unexpected row, dest_offset", 0, dest_offset);
            return;
        end
        want = expected_rows.pop_front();
        if (dest_offset !== want.dest)
            report_mismatch("dest_offset", want.dest, dest_offset);
        if (source_offset !== want.src)
            report_mismatch("source_offset", want.src, source_offset);
        if (run_length !== want.run)
            report_mismatch("run_length", want.run, run_length);
        if (last_row !== want.last)
            report_mismatch("last_row", want.last, last_row);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width = 13'd640;
            screen_height = 13'd480;
            palette_width = 13'd256;
            fail_count = 0;
            expected_rows.delete();
            rows_pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                apply_register(cfg_index, cfg_data);
            if (strobe)
                check_row();
            if (start && !busy)
                predict_tile_rows(cell_column, cell_row, tile_number);
            rows_pending <= expected_rows.size();
        end
    end

endmodule

// ===== tb/tile_blit_row_generator_test.sv =====
// testbench top for the tile blit row generator: clock, reset, config
// phases and cell stimulus, verdict from the checker's failure count;
// depends on tbr_test_pkg, the checker and the block
module tile_blit_row_generator_test;

    localparam int SETTLE_CYCLES = 40;
    localparam int TILE_PIXELS   = tbr_test_pkg::TILE_PIXELS;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [7:0]  cell_column = '0;
    logic [7:0]  cell_row = '0;
    logic [15:0] tile_number = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = tbr_test_pkg::CFG_SCREEN_WIDTH;
    logic [12:0] cfg_data = '0;
    logic        strobe;
    logic [23:0] dest_offset;
    logic [23:0] source_offset;
    logic [6:0]  run_length;
    logic        last_row;
    int          rows_pending;
    int          fail_count;

    int          gap_limit = 8;
    int          cur_width = 640;
    int          cur_height = 480;

    tile_blit_row_generator #(
        .TILE_PIXELS(TILE_PIXELS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cell_column(cell_column),
        .cell_row(cell_row),
        .tile_number(tile_number),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .strobe(strobe),
        .dest_offset(dest_offset),
        .source_offset(source_offset),
        .run_length(run_length),
        .last_row(last_row)
    );

    tile_blit_row_generator_checker i_checker (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cell_column(cell_column),
        .cell_row(cell_row),
        .tile_number(tile_number),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .strobe(strobe),
        .dest_offset(dest_offset),
        .source_offset(source_offset),
        .run_length(run_length),
        .last_row(last_row),
        .rows_pending(rows_pending),
        .fail_count(fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic send_cell(input logic [7:0] col, input logic [7:0] row,
                             input logic [15:0] tile);
        int gap;
        gap = $urandom_range(gap_limit);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cell_column <= col;
        cell_row <= row;
        tile_number <= tile;
        do @(posedge clk); while (busy);
    endtask

    // mostly cells that land on screen, the rest anywhere on the map
    task automatic send_random_cell;
        int vis_cols;
        int vis_rows;
        logic [7:0] col;
        logic [7:0] row;
        logic [15:0] tile;
        vis_cols = (cur_width + TILE_PIXELS - 1) / TILE_PIXELS;
        vis_rows = (cur_height + TILE_PIXELS - 1) / TILE_PIXELS;
        vis_cols = (vis_cols < 1) ? 1 : (vis_cols > 256) ? 256 : vis_cols;
        vis_rows = (vis_rows < 1) ? 1 : (vis_rows > 256) ? 256 : vis_rows;
        col = ($urandom_range(9) < 8) ? 8'($urandom_range(vis_cols - 1)) : 8'($urandom());
        row = ($urandom_range(9) < 8) ? 8'($urandom_range(vis_rows - 1)) : 8'($urandom());
        case ($urandom_range(9))
            0: tile = 16'd0;
            1, 2, 3: tile = 16'($urandom());
            default: tile = 16'($urandom_range(64, 1));
        endcase
        send_cell(col, row, tile);
    endtask

    // rows already predicted must all arrive; empty cells may still be in flight
    task automatic wait_idle;
        start <= 1'b0;
        @(posedge clk);
        while (rows_pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input tbr_test_pkg::cfg_reg_t index, input logic [12:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic set_config(input int width, input int height, input int pal);
        wait_idle();
        write_register(tbr_test_pkg::CFG_SCREEN_WIDTH, 13'(width));
        write_register(tbr_test_pkg::CFG_SCREEN_HEIGHT, 13'(height));
        write_register(tbr_test_pkg::CFG_PALETTE_WIDTH, 13'(pal));
        cfg_valid <= 1'b0;
        cur_width = width;
        cur_height = height;
    endtask

    task automatic run_phase(input int width, input int height, input int pal,
                             input int count, input int gaps);
        set_config(width, height, pal);
        gap_limit = gaps;
        repeat (count) send_random_cell();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset sizes: empty, corners, clipping, palette wrap
        send_cell(8'd0, 8'd0, 16'd0);
        send_cell(8'd0, 8'd0, 16'd1);
        send_cell(8'd19, 8'd14, 16'd8);
        send_cell(8'd20, 8'd0, 16'd1);
        send_cell(8'd0, 8'd15, 16'd1);
        send_cell(8'd255, 8'd255, 16'hFFFF);
        send_cell(8'd0, 8'd0, 16'hFFFF);
        send_cell(8'd1, 8'd1, 16'd9);

        // partial clip on both edges, palette narrower than a tile
        set_config(100, 70, 20);
        send_cell(8'd3, 8'd0, 16'd5);
        send_cell(8'd0, 8'd2, 16'd3);
        send_cell(8'd3, 8'd2, 16'hFFFF);
        send_cell(8'd4, 8'd0, 16'd2);

        // write to the unused index must change nothing
        wait_idle();
        write_register(tbr_test_pkg::CFG_UNUSED, 13'h1FFF);
        cfg_valid <= 1'b0;
        send_cell(8'd0, 8'd0, 16'd2);

        // zero sizes clip everything
        set_config(0, 0, 0);
        send_cell(8'd0, 8'd0, 16'd1);

        set_config(8191, 8191, 8191);
        send_cell(8'd255, 8'd255, 16'hFFFF);
        send_cell(8'd0, 8'd0, 16'd1);
        send_cell(8'd255, 8'd0, 16'hAAAA);

        set_config(1, 1, 1);
        send_cell(8'd0, 8'd0, 16'd1);
        send_cell(8'd0, 8'd0, 16'hFFFF);
        send_cell(8'd1, 8'd0, 16'd1);

        run_phase(640, 480, 256, 35, 8);
        run_phase(8191, 8191, 8191, 30, 0);
        run_phase(100, 70, 20, 30, 8);
        run_phase(1, 1, 1, 15, 8);
        run_phase(0, 480, 0, 8, 0);
        run_phase(4096, 4096, 4096, 25, 8);
        repeat (3)
            run_phase($urandom_range(4096, 1), $urandom_range(4096, 1),
                      $urandom_range(4096, 1), 20, 8);
        run_phase($urandom_range(8191), $urandom_range(8191), $urandom_range(8191), 15, 0);

        wait_idle();
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/tbr_pkg.sv
hdl/tbr_div_stage.sv
hdl/tbr_offset.sv
hdl/tbr_row_emit.sv
hdl/tile_blit_row_generator.sv
tb/tbr_test_pkg.sv
tb/tile_blit_row_generator_checker.sv
tb/tile_blit_row_generator_test.sv
